@@ hdl/ball_intake_stack_sequencer_defines.svh @@
// assertion macros for the top-level rtl file
`ifndef BALL_INTAKE_STACK_SEQUENCER_DEFINES_SVH
`define BALL_INTAKE_STACK_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on clk, held off during reset
`define BIS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BIS_ASSERT_IMPL(label, ante, cons, msg)
`define BIS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/bis_pkg.sv @@
package bis_pkg;

    localparam int DIST_W  = 14;
    localparam int COUNT_W = 6;
    localparam int SLOTS_W = 4;
    localparam int TOTAL_W = 7;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = ADDR_W - 2;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_LOAD,
        PH_STACK,
        PH_FULL
    } phase_t;

    typedef enum logic [2:0] {
        UP_COAST,
        UP_BRAKE,
        UP_FEED,
        UP_HOLD,
        UP_REVERSE
    } up_cmd_t;

    typedef enum logic [1:0] {
        S2_COAST,
        S2_BRAKE,
        S2_DOWN,
        S2_LIFT
    } s2_cmd_t;

    localparam logic [MODE_W-1:0] MODE_INTAKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUTTAKE = 2'd2;

    localparam logic [IDX_W-1:0] REG_ENTRY_THR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_STORAGE_THR = 3'd1;
    localparam logic [IDX_W-1:0] REG_TOP_THR     = 3'd2;
    localparam logic [IDX_W-1:0] REG_STACK_TGT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SLOTS       = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD_EN     = 3'd5;

    typedef struct packed {
        logic [DIST_W-1:0]  entry_thr;
        logic [DIST_W-1:0]  storage_thr;
        logic [DIST_W-1:0]  top_thr;
        logic [COUNT_W-1:0] stack_target;
        logic [SLOTS_W-1:0] storage_slots;
        logic               hold_enable;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] entry_dist;
        logic [DIST_W-1:0] storage_dist;
        logic [DIST_W-1:0] top_dist;
        logic [MODE_W-1:0] run_mode;
        logic              clear;
    } sample_t;

    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] ball_count;
        logic               storage_full;
        logic               entry_last;
        logic               top_last;
        up_cmd_t            upstream;
        s2_cmd_t            stage_two;
    } state_t;

    typedef struct packed {
        up_cmd_t            upstream;
        s2_cmd_t            stage_two;
        logic [COUNT_W-1:0] stack_count;
        logic               storage_held;
        logic [TOTAL_W-1:0] total_count;
        phase_t             phase;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        entry_thr:     14'd50,
        storage_thr:   14'd50,
        top_thr:       14'd50,
        stack_target:  6'd10,
        storage_slots: 4'd1,
        hold_enable:   1'b0
    };

    localparam state_t STATE_RESET = '{
        phase:        PH_SEEK,
        ball_count:   '0,
        storage_full: 1'b0,
        entry_last:   1'b0,
        top_last:     1'b0,
        upstream:     UP_COAST,
        stage_two:    S2_COAST
    };

    // a reading of zero means no echo, so it never counts
    function automatic logic present(input logic [DIST_W-1:0] dist_mm,
                                     input logic [DIST_W-1:0] thr);
        return (dist_mm != '0) && (dist_mm <= thr);
    endfunction

endpackage

@@ hdl/ball_intake_stack_sequencer.sv @@
// ball intake stack sequencer
// one input word is one control tick: three distance samples in mm, a run
// mode and a clear flag. each tick gives exactly one result word with the
// upstream roller and stage two command codes, the stack count, the storage
// flag, the total count and the intake phase.
// both channels use valid/stall; a word moves on a rising edge with valid high
// and stall low. thresholds, stack target, storage slots and hold enable sit
// behind the apb port at byte addresses 0, 4, 8, 12, 16 and 20.
// a word accepted into the input register is stepped through the sequencer
// logic into the result register once the output is free, and is shown on
// the output from then on. throughput: one word per cycle while out_stall
// is low; the input register and the result register each hold one word,
// and the sequencer state updates once per word.
// if the receiver stalls, the result is held, the input register fills and
// then in_stall is raised until the result is taken.
// reset clears the pipeline, puts the sequencer in seek with zero counts and
// both rollers coasting, and loads the register defaults.
`include "ball_intake_stack_sequencer_defines.svh"

module ball_intake_stack_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bis_pkg::ADDR_W-1:0]    paddr,
    input  logic [bis_pkg::DATA_W-1:0]    pwdata,
    output logic [bis_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bis_pkg::DIST_W-1:0]    entry_distance,
    input  logic [bis_pkg::DIST_W-1:0]    storage_distance,
    input  logic [bis_pkg::DIST_W-1:0]    top_distance,
    input  logic [bis_pkg::MODE_W-1:0]    run_mode,
    input  logic                          clear_counts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    upstream_cmd,
    output logic [1:0]                    stage_two_cmd,
    output logic [bis_pkg::COUNT_W-1:0]   stack_count,
    output logic                          storage_held,
    output logic [bis_pkg::TOTAL_W-1:0]   total_count,
    output logic [1:0]                    intake_phase_out
);
    import bis_pkg::*;

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic [IDX_W-1:0]  cfg_idx;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    sample_t           s1_sample_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           result_reg;
    state_t            state_reg;
    state_t            state_next;
    result_t           result_next;

    logic              out_free;
    logic              advance;
    logic              in_accept;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ENTRY_THR:   cfg_reg.entry_thr     <= pwdata[DIST_W-1:0];
                REG_STORAGE_THR: cfg_reg.storage_thr   <= pwdata[DIST_W-1:0];
                REG_TOP_THR:     cfg_reg.top_thr       <= pwdata[DIST_W-1:0];
                REG_STACK_TGT:   cfg_reg.stack_target  <= pwdata[COUNT_W-1:0];
                REG_SLOTS:       cfg_reg.storage_slots <= pwdata[SLOTS_W-1:0];
                REG_HOLD_EN:     cfg_reg.hold_enable   <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ENTRY_THR:   prdata = DATA_W'(cfg_reg.entry_thr);
            REG_STORAGE_THR: prdata = DATA_W'(cfg_reg.storage_thr);
            REG_TOP_THR:     prdata = DATA_W'(cfg_reg.top_thr);
            REG_STACK_TGT:   prdata = DATA_W'(cfg_reg.stack_target);
            REG_SLOTS:       prdata = DATA_W'(cfg_reg.storage_slots);
            REG_HOLD_EN:     prdata = DATA_W'(cfg_reg.hold_enable);
            default:         prdata = '0;
        endcase
    end

    // pipeline handshake
    assign out_free       = !out_valid_reg || !out_stall;
    assign advance        = s1_valid_reg && out_free;
    assign in_stall       = s1_valid_reg && !out_free;
    assign in_accept      = in_valid && !in_stall;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg.entry_dist   <= entry_distance;
            s1_sample_reg.storage_dist <= storage_distance;
            s1_sample_reg.top_dist     <= top_distance;
            s1_sample_reg.run_mode     <= run_mode;
            s1_sample_reg.clear        <= clear_counts;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    bis_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .sample     (s1_sample_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign out_valid        = out_valid_reg;
    assign upstream_cmd     = result_reg.upstream;
    assign stage_two_cmd    = result_reg.stage_two;
    assign stack_count      = result_reg.stack_count;
    assign storage_held     = result_reg.storage_held;
    assign total_count      = result_reg.total_count;
    assign intake_phase_out = result_reg.phase;

    `BIS_ASSERT_IMPL(a_load_not_full, state_reg.phase == PH_LOAD, !state_reg.storage_full, "loading phase with storage already full")
    `BIS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_reg), "sequencer state moved without a word")
    `BIS_ASSERT_IMPL(a_stall_cause, in_stall, s1_valid_reg && out_valid_reg && out_stall, "input stalled with room downstream")
    `BIS_ASSERT_NEXT(a_result_shown, advance, out_valid_reg, "stepped word not presented")

endmodule

@@ hdl/bis_step.sv @@
module bis_step (
    input  bis_pkg::state_t                 state,
    input  bis_pkg::cfg_t                   cfg,
    input  bis_pkg::sample_t                sample,
    output bis_pkg::state_t                 state_next,
    output bis_pkg::result_t                result
);
    import bis_pkg::*;

    logic               entry;
    logic               storage;
    logic               top;
    logic [COUNT_W-1:0] count_inc;

    assign entry     = present(sample.entry_dist, cfg.entry_thr);
    assign storage   = present(sample.storage_dist, cfg.storage_thr);
    assign top       = present(sample.top_dist, cfg.top_thr);
    assign count_inc = state.ball_count + COUNT_W'(1);

    always_comb
    begin
        state_next = state;
        if (sample.clear)
        begin
            // motor commands are left as they were
            state_next.ball_count   = '0;
            state_next.storage_full = 1'b0;
            state_next.phase        = PH_SEEK;
            state_next.entry_last   = 1'b0;
            state_next.top_last     = 1'b0;
        end
        else
        begin
            unique case (sample.run_mode)
                MODE_INTAKE:
                begin
                    unique case (state.phase)
                        PH_SEEK:
                        begin
                            if (state.storage_full)
                            begin
                                state_next.phase = PH_STACK;
                            end
                            else
                            begin
                                state_next.upstream  = UP_FEED;
                                state_next.stage_two = S2_BRAKE;
                                if (entry)
                                begin
                                    state_next.phase = PH_LOAD;
                                end
                            end
                        end
                        PH_LOAD:
                        begin
                            state_next.upstream  = UP_FEED;
                            state_next.stage_two = S2_DOWN;
                            if (storage)
                            begin
                                state_next.storage_full = 1'b1;
                                state_next.stage_two    = S2_BRAKE;
                                state_next.phase        = PH_STACK;
                            end
                        end
                        PH_STACK:
                        begin
                            if (state.ball_count >= cfg.stack_target)
                            begin
                                state_next.phase = PH_FULL;
                            end
                            else
                            begin
                                state_next.upstream = UP_FEED;
                            end
                        end
                        PH_FULL:
                        begin
                            state_next.upstream = cfg.hold_enable ? UP_HOLD : UP_BRAKE;
                            if (state.ball_count < cfg.stack_target)
                            begin
                                state_next.phase = PH_STACK;
                            end
                        end
                    endcase
                    // count a ball on the rising edge at the entry sensor
                    if (state_next.storage_full && state_next.phase == PH_STACK &&
                        state.ball_count < cfg.stack_target && entry && !state.entry_last)
                    begin
                        state_next.ball_count = count_inc;
                        if (count_inc >= cfg.stack_target)
                        begin
                            state_next.phase = PH_FULL;
                        end
                    end
                end
                MODE_OUTTAKE:
                begin
                    if (state.ball_count != '0)
                    begin
                        state_next.upstream = UP_REVERSE;
                        // a ball leaving the top sensor
                        if (state.top_last && !top)
                        begin
                            state_next.ball_count = state.ball_count - COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next.upstream = UP_COAST;
                        if (state.storage_full)
                        begin
                            state_next.stage_two = S2_LIFT;
                            if (top)
                            begin
                                state_next.storage_full = 1'b0;
                            end
                        end
                        else
                        begin
                            state_next.stage_two = S2_COAST;
                        end
                    end
                end
                default:
                begin
                    state_next.upstream  = UP_COAST;
                    state_next.stage_two = S2_COAST;
                end
            endcase
            state_next.entry_last = entry;
            state_next.top_last   = top;
        end
    end

    always_comb
    begin
        result.upstream     = state_next.upstream;
        result.stage_two    = state_next.stage_two;
        result.stack_count  = state_next.ball_count;
        result.storage_held = state_next.storage_full;
        result.total_count  = TOTAL_W'(state_next.ball_count) +
                              (state_next.storage_full ? TOTAL_W'(cfg.storage_slots)
                                                       : TOTAL_W'(0));
        result.phase        = state_next.phase;
    end

endmodule

@@ bench/tb_ball_intake_stack_sequencer.sv @@
`timescale 1ns / 100ps

module tb_ball_intake_stack_sequencer;

    import bis_pkg::*;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int TICKS_END    = 1250;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [DIST_W-1:0]    entry_distance = '0;
    logic [DIST_W-1:0]    storage_distance = '0;
    logic [DIST_W-1:0]    top_distance = '0;
    logic [MODE_W-1:0]    run_mode = '0;
    logic                 clear_counts = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           upstream_cmd;
    logic [1:0]           stage_two_cmd;
    logic [COUNT_W-1:0]   stack_count;
    logic                 storage_held;
    logic [TOTAL_W-1:0]   total_count;
    logic [1:0]           intake_phase_out;

    cfg_t    cfg_shadow = CFG_RESET;
    state_t  seq_state = STATE_RESET;
    result_t reports_due[$];

    int stall_pct = 25;
    int gap_max = 3;
    int burst_left = 0;
    int ticks_sent = 0;
    int errors = 0;
    int cycle_count = 0;
    bit long_hold_req = 1'b0;

    ball_intake_stack_sequencer u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .entry_distance   (entry_distance),
        .storage_distance (storage_distance),
        .top_distance     (top_distance),
        .run_mode         (run_mode),
        .clear_counts     (clear_counts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .upstream_cmd     (upstream_cmd),
        .stage_two_cmd    (stage_two_cmd),
        .stack_count      (stack_count),
        .storage_held     (storage_held),
        .total_count      (total_count),
        .intake_phase_out (intake_phase_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic ball_seen(input logic [DIST_W-1:0] d,
                                       input logic [DIST_W-1:0] thr);
        return (d > 0) && (d <= thr);
    endfunction

    // one control tick of the sequencer, updating the shadow state
    function automatic result_t predict_tick(input sample_t s);
        logic    ent;
        logic    sto;
        logic    topp;
        result_t r;
        if (s.clear)
        begin
            seq_state.phase        = PH_SEEK;
            seq_state.ball_count   = '0;
            seq_state.storage_full = 1'b0;
            seq_state.entry_last   = 1'b0;
            seq_state.top_last     = 1'b0;
        end
        else
        begin
            ent  = ball_seen(s.entry_dist, cfg_shadow.entry_thr);
            sto  = ball_seen(s.storage_dist, cfg_shadow.storage_thr);
            topp = ball_seen(s.top_dist, cfg_shadow.top_thr);
            if (s.run_mode == MODE_INTAKE)
            begin
                case (seq_state.phase)
                    PH_SEEK:
                    begin
                        if (seq_state.storage_full)
                            seq_state.phase = PH_STACK;
                        else
                        begin
                            seq_state.upstream  = UP_FEED;
                            seq_state.stage_two = S2_BRAKE;
                            if (ent)
                                seq_state.phase = PH_LOAD;
                        end
                    end
                    PH_LOAD:
                    begin
                        seq_state.upstream  = UP_FEED;
                        seq_state.stage_two = S2_DOWN;
                        if (sto)
                        begin
                            seq_state.storage_full = 1'b1;
                            seq_state.stage_two    = S2_BRAKE;
                            seq_state.phase        = PH_STACK;
                        end
                    end
                    PH_STACK:
                    begin
                        if (seq_state.ball_count >= cfg_shadow.stack_target)
                            seq_state.phase = PH_FULL;
                        else
                            seq_state.upstream = UP_FEED;
                    end
                    default:
                    begin
                        seq_state.upstream = cfg_shadow.hold_enable ? UP_HOLD : UP_BRAKE;
                        if (seq_state.ball_count < cfg_shadow.stack_target)
                            seq_state.phase = PH_STACK;
                    end
                endcase
                // count a ball on each rising edge at the entry sensor
                if (seq_state.storage_full && seq_state.phase == PH_STACK &&
                    seq_state.ball_count < cfg_shadow.stack_target && ent &&
                    !seq_state.entry_last)
                begin
                    seq_state.ball_count = seq_state.ball_count + 1'b1;
                    if (seq_state.ball_count >= cfg_shadow.stack_target)
                        seq_state.phase = PH_FULL;
                end
            end
            else if (s.run_mode == MODE_OUTTAKE)
            begin
                if (seq_state.ball_count > 0)
                begin
                    seq_state.upstream = UP_REVERSE;
                    if (seq_state.top_last && !topp)
                        seq_state.ball_count = seq_state.ball_count - 1'b1;
                end
                else
                begin
                    seq_state.upstream = UP_COAST;
                    if (seq_state.storage_full)
                    begin
                        seq_state.stage_two = S2_LIFT;
                        if (topp)
                            seq_state.storage_full = 1'b0;
                    end
                    else
                        seq_state.stage_two = S2_COAST;
                end
            end
            else
            begin
                seq_state.upstream  = UP_COAST;
                seq_state.stage_two = S2_COAST;
            end
            seq_state.entry_last = ent;
            seq_state.top_last   = topp;
        end
        r.upstream     = seq_state.upstream;
        r.stage_two    = seq_state.stage_two;
        r.stack_count  = seq_state.ball_count;
        r.storage_held = seq_state.storage_full;
        r.total_count  = TOTAL_W'(seq_state.ball_count) +
                         (seq_state.storage_full ? TOTAL_W'(cfg_shadow.storage_slots) : '0);
        r.phase        = seq_state.phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t result word with nothing due", $time);
                errors++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("upstream_cmd", 8'(want.upstream), 8'(upstream_cmd));
                check_field("stage_two_cmd", 8'(want.stage_two), 8'(stage_two_cmd));
                check_field("stack_count", 8'(want.stack_count), 8'(stack_count));
                check_field("storage_held", 8'(want.storage_held), 8'(storage_held));
                check_field("total_count", 8'(want.total_count), 8'(total_count));
                check_field("intake_phase_out", 8'(want.phase), 8'(intake_phase_out));
            end
        end
    end

    // receiver: runs of stall and no stall, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int run_left;
        bit run_stall;
        hold_left = 0;
        run_left = 0;
        run_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 12);
                    run_stall = ($urandom_range(99) < stall_pct);
                end
                run_left--;
                out_stall <= run_stall;
            end
        end
    end

    task automatic idle_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_tick(input int e, input int st, input int tp,
                             input logic [MODE_W-1:0] mode, input logic clr);
        sample_t smp;
        bit      taken;
        int      gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
                idle_sender(gap);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        smp.entry_dist   = 14'(e);
        smp.storage_dist = 14'(st);
        smp.top_dist     = 14'(tp);
        smp.run_mode     = mode;
        smp.clear        = clr;
        entry_distance   <= smp.entry_dist;
        storage_distance <= smp.storage_dist;
        top_distance     <= smp.top_dist;
        run_mode         <= smp.run_mode;
        clear_counts     <= smp.clear;
        in_valid         <= 1'b1;
        // stall is settled by the falling edge, the word moves at the next rising one
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        reports_due.push_back(predict_tick(smp));
        ticks_sent++;
    endtask

    task automatic drain();
        idle_sender(1);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENTRY_THR:   cfg_shadow.entry_thr     = value[DIST_W-1:0];
            REG_STORAGE_THR: cfg_shadow.storage_thr   = value[DIST_W-1:0];
            REG_TOP_THR:     cfg_shadow.top_thr       = value[DIST_W-1:0];
            REG_STACK_TGT:   cfg_shadow.stack_target  = value[COUNT_W-1:0];
            REG_SLOTS:       cfg_shadow.storage_slots = value[SLOTS_W-1:0];
            REG_HOLD_EN:     cfg_shadow.hold_enable   = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input int e, input int st, input int tp,
                                input int tgt, input int slots, input int hold);
        write_reg(REG_ENTRY_THR, e);
        write_reg(REG_STORAGE_THR, st);
        write_reg(REG_TOP_THR, tp);
        write_reg(REG_STACK_TGT, tgt);
        write_reg(REG_SLOTS, slots);
        write_reg(REG_HOLD_EN, hold);
    endtask

    function automatic int pick_threshold();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 0;
        if (r == 1)
            return 9999;
        return $urandom_range(1, 400);
    endfunction

    function automatic int pick_dist(input int thr, input bit want);
        if ($urandom_range(9) == 0)
            return $urandom_range(9999);
        if (want && thr > 0)
            return $urandom_range(thr, 1);
        if (!want && thr < 9999 && $urandom_range(3) != 0)
            return $urandom_range(9999, thr + 1);
        return 0;
    endfunction

    task automatic random_tick(input logic [MODE_W-1:0] mode, input int p_ent,
                               input int p_sto, input int p_top);
        logic [MODE_W-1:0] m;
        logic              clr;
        int                e;
        int                st;
        int                tp;
        m   = ($urandom_range(99) < 5) ? MODE_W'($urandom_range(3)) : mode;
        clr = ($urandom_range(99) < 2);
        e   = pick_dist(cfg_shadow.entry_thr, $urandom_range(99) < p_ent);
        st  = pick_dist(cfg_shadow.storage_thr, $urandom_range(99) < p_sto);
        tp  = pick_dist(cfg_shadow.top_thr, $urandom_range(99) < p_top);
        send_tick(e, st, tp, m, clr);
    endtask

    // fill the stack in intake, then empty it and release storage in outtake
    task automatic run_fill_cycle();
        int n;
        n = 4 * cfg_shadow.stack_target + $urandom_range(8, 24);
        repeat (n) random_tick(MODE_INTAKE, 50, 25, 30);
        n = 4 * seq_state.ball_count + $urandom_range(8, 20);
        repeat (n) random_tick(MODE_OUTTAKE, 30, 30, 50);
        repeat ($urandom_range(0, 4)) random_tick(MODE_W'($urandom_range(3)), 50, 50, 50);
    endtask

    task automatic test_directed_sequence();
        send_tick(0, 0, 0, MODE_OFF, 1'b0);
        send_tick(9999, 9999, 9999, MODE_UNDEF, 1'b0);
        send_tick(0, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(50, 0, 0, MODE_INTAKE, 1'b0);      // threshold exactly: seen
        send_tick(0, 51, 0, MODE_INTAKE, 1'b0);      // one above: not seen
        send_tick(0, 50, 0, MODE_INTAKE, 1'b0);
        send_tick(1, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(9999, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(49, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 0, 20, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 20, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 9999, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 10, MODE_OUTTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_OUTTAKE, 1'b0);
        send_tick(5, 0, 0, MODE_INTAKE, 1'b0);       // stacking with storage empty
        send_tick(5, 5, 5, MODE_INTAKE, 1'b1);
    endtask

    task automatic test_register_extremes();
        drain();
        apply_config(9999, 9999, 0, 0, 15, 1);
        send_tick(9999, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 1, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 0, 0, MODE_INTAKE, 1'b0);
        send_tick(0, 0, 5, MODE_OUTTAKE, 1'b0);      // top threshold zero: never seen
        drain();
        apply_config(0, 50, 9999, 63, 0, 0);
        repeat (6) random_tick(MODE_INTAKE, 50, 50, 50);
    endtask

    task automatic test_random_sequences();
        while (ticks_sent < TICKS_END)
        begin
            drain();
            if ($urandom_range(3) == 0)
                apply_config(CFG_RESET.entry_thr, CFG_RESET.storage_thr, CFG_RESET.top_thr,
                             $urandom_range(0, 12), $urandom_range(0, 15), $urandom_range(1));
            else
                apply_config(pick_threshold(), pick_threshold(), pick_threshold(),
                             ($urandom_range(9) == 0) ? 63 : $urandom_range(0, 12),
                             $urandom_range(0, 15), $urandom_range(1));
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 75;
            endcase
            case ($urandom_range(2))
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 8;
            endcase
            repeat ($urandom_range(1, 3)) run_fill_cycle();
        end
    endtask

    task automatic test_input_backpressure();
        drain();
        stall_pct = 0;
        gap_max = 0;
        long_hold_req = 1'b1;
        repeat (40) random_tick(MODE_INTAKE, 50, 30, 30);
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequence();
        test_register_extremes();
        test_input_backpressure();
        test_random_sequences();
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bis_pkg.sv
hdl/bis_step.sv
hdl/ball_intake_stack_sequencer.sv
bench/tb_ball_intake_stack_sequencer.sv
